/* rtl/fbpa_pkg.sv */
// Package for the fixed block pool allocator: field widths, operation and
// status codes, register indexes and the shared structs.
// Depends on nothing; every other file of the block imports it.
package fbpa_pkg;

  localparam int MAX_BLOCKS_DEF    = 256;
  localparam int ADDRESS_WIDTH_DEF = 32;

  // Fixed widths of the channel fields.
  localparam int OP_W       = 2;
  localparam int IN_ADDR_W  = 32;
  localparam int OUT_ADDR_W = 32;
  localparam int OUT_CNT_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int SIZE_W     = 17;
  localparam int COUNT_W    = 9;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [IN_ADDR_W-1:0] base_address;
    logic [SIZE_W-1:0]    block_size;
    logic [COUNT_W-1:0]   block_count;
  } cfg_t;

  typedef struct packed {
    status_t               status;
    logic [OUT_ADDR_W-1:0] granted_address;
    logic [OUT_CNT_W-1:0]  free_blocks;
  } res_t;

  // Access strobes from the sequencer to the ring memory.
  typedef struct packed {
    logic wr;
    logic rd;
  } ring_cmd_t;

  // Index width for a ring of the given depth; at least one bit.
  function automatic int idx_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

/* rtl/fbpa_if.sv */
// Channel interfaces of the fixed block pool allocator: configuration
// writes, request items and result items, each with valid and ready.
// Depends on fbpa_pkg for the field widths.
interface fbpa_cfg_if;
  import fbpa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface fbpa_req_if;
  import fbpa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [IN_ADDR_W-1:0] block_address;
  modport source (output valid, output operation, output block_address, input ready);
  modport sink (input valid, input operation, input block_address, output ready);
endinterface

interface fbpa_rsp_if;
  import fbpa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [OUT_ADDR_W-1:0] granted_address;
  logic [OUT_CNT_W-1:0]  free_blocks;
  modport source (output valid, output status, output granted_address, output free_blocks,
                  input ready);
  modport sink (input valid, input status, input granted_address, input free_blocks,
                output ready);
endinterface

/* rtl/fbpa_ring_mem.sv */
// Free-list ring storage: a single-port synchronous memory with a
// registered read. Depends on fbpa_pkg for the access strobe struct.
module fbpa_ring_mem #(
  parameter int DEPTH = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int WIDTH = fbpa_pkg::ADDRESS_WIDTH_DEF,
  localparam int IDX_W = fbpa_pkg::idx_width(DEPTH)
) (
  input  logic                  clk,
  input  fbpa_pkg::ring_cmd_t   cmd,
  input  logic [IDX_W-1:0]      idx,
  input  logic [WIDTH-1:0]      wdata,
  output logic [WIDTH-1:0]      rdata
);
  import fbpa_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[idx] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[idx];
    end
  end

endmodule

/* rtl/fbpa_ctrl.sv */
// Sequencer of the fixed block pool allocator: ring pointers, free count,
// the initialize walk and the result register with its holding stage.
// Depends on fbpa_pkg and fbpa_if; drives the ring memory port.
module fbpa_ctrl #(
  parameter int MAX_BLOCKS    = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int ADDRESS_WIDTH = fbpa_pkg::ADDRESS_WIDTH_DEF,
  localparam int IDX_W = fbpa_pkg::idx_width(MAX_BLOCKS),
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  fbpa_pkg::cfg_t           cfg_regs,
  fbpa_req_if.sink                 req,
  fbpa_rsp_if.source               rsp,
  output fbpa_pkg::ring_cmd_t      ring_cmd,
  output logic [IDX_W-1:0]         ring_idx,
  output logic [ADDRESS_WIDTH-1:0] ring_wdata,
  input  logic [ADDRESS_WIDTH-1:0] ring_rdata
);
  import fbpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_INIT = 4'b0100,
    S_PEND = 4'b1000
  } state_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(MAX_BLOCKS - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  state_t                   state, state_next;
  logic [IDX_W-1:0]         head, head_next;
  logic [IDX_W-1:0]         tail, tail_next;
  logic [CNT_W-1:0]         total, total_next;
  logic [ADDRESS_WIDTH-1:0] walk_addr, walk_addr_next;
  logic [CNT_W-1:0]         walk_count, walk_count_next;
  logic [CNT_W-1:0]         init_count;

  logic out_valid;
  res_t out_res;
  res_t pend_res;
  res_t res;
  logic res_valid;
  logic out_free;
  logic out_load_res;
  logic out_load_pend;
  logic pend_load;

  assign req.ready = (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;

  // Block count saturates at the ring depth.
  assign init_count = (32'(cfg_regs.block_count) > 32'(MAX_BLOCKS)) ?
                      CNT_W'(MAX_BLOCKS) : CNT_W'(cfg_regs.block_count);

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    total_next      = total;
    walk_addr_next  = walk_addr;
    walk_count_next = walk_count;
    ring_cmd        = '0;
    ring_idx        = '0;
    ring_wdata      = '0;
    res_valid       = 1'b0;
    res.status          = ST_OK;
    res.granted_address = '0;
    out_load_res    = 1'b0;
    out_load_pend   = 1'b0;
    pend_load       = 1'b0;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (req.operation)
            OP_ALLOC: begin
              if (total == '0) begin
                res_valid  = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                ring_cmd.rd = 1'b1;
                ring_idx    = head;
                head_next   = ring_next(head);
                total_next  = total - CNT_W'(1);
                state_next  = S_READ;
              end
            end
            OP_FREE: begin
              res_valid = 1'b1;
              if (total == CNT_W'(MAX_BLOCKS)) begin
                res.status = ST_FULL;
              end else begin
                ring_cmd.wr = 1'b1;
                ring_idx    = tail;
                ring_wdata  = ADDRESS_WIDTH'(req.block_address);
                tail_next   = ring_next(tail);
                total_next  = total + CNT_W'(1);
              end
            end
            OP_INIT: begin
              // The walk refills the ring from entry 0, using the tail and
              // the free count as its write pointer and counter.
              head_next       = '0;
              tail_next       = '0;
              total_next      = '0;
              walk_addr_next  = ADDRESS_WIDTH'(cfg_regs.base_address);
              walk_count_next = init_count;
              if (init_count == '0) begin
                res_valid = 1'b1;
              end else begin
                state_next = S_INIT;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res_valid           = 1'b1;
        res.granted_address = OUT_ADDR_W'(ring_rdata);
      end
      S_INIT: begin
        ring_cmd.wr    = 1'b1;
        ring_idx       = tail;
        ring_wdata     = walk_addr;
        tail_next      = ring_next(tail);
        total_next     = total + CNT_W'(1);
        walk_addr_next = walk_addr + ADDRESS_WIDTH'(cfg_regs.block_size);
        if (total_next == walk_count) begin
          res_valid = 1'b1;
        end
      end
      S_PEND: begin
        if (out_free) begin
          out_load_pend = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res.free_blocks = OUT_CNT_W'(total_next);

    if (res_valid) begin
      if (out_free) begin
        out_load_res = 1'b1;
        state_next   = S_IDLE;
      end else begin
        pend_load  = 1'b1;
        state_next = S_PEND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      total      <= '0;
      walk_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      total      <= total_next;
      walk_count <= walk_count_next;
      if (out_load_res || out_load_pend) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_addr <= walk_addr_next;
    if (out_load_res) begin
      out_res <= res;
    end else if (out_load_pend) begin
      out_res <= pend_res;
    end
    if (pend_load) begin
      pend_res <= res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_res.status;
  assign rsp.granted_address = out_res.granted_address;
  assign rsp.free_blocks     = out_res.free_blocks;

endmodule

/* rtl/fixed_block_pool_allocator.sv */
// Top level of the fixed block pool allocator: configuration registers,
// the sequencer and the free-list ring memory.
// Depends on fbpa_pkg, fbpa_if, fbpa_ring_mem and fbpa_ctrl.
//
// Usage. Registers (base address, block size, block count) are written on
// the cfg channel, which is always ready; write them only while the block
// is idle. Request items on req carry an operation and, for a free, the
// returned block address. Each request yields exactly one result item on
// rsp with a status, the granted address and the free count after it.
// Free and an unused operation code load the result register straight
// from idle; allocate first passes the read state, as the ring memory
// read is registered; initialize writes one ring entry per cycle through
// the single memory port, for the saturated block count. One item
// is in work at a time; req is ready again once the result is produced.
// While a result waits on a stalled rsp, one more item may be accepted; its
// result waits in a holding register and req stays low until it moves on.
// Reset empties the free list and loads the register defaults; the ring
// itself is not cleared, since only entries written since are ever read.
// A free written in one cycle is visible to an allocate in the next, so
// no forwarding is needed around the memory.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS    = fbpa_pkg::MAX_BLOCKS_DEF,
  parameter int ADDRESS_WIDTH = fbpa_pkg::ADDRESS_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  fbpa_cfg_if.sink   cfg,
  fbpa_req_if.sink   req,
  fbpa_rsp_if.source rsp
);
  import fbpa_pkg::*;

  localparam int IDX_W = idx_width(MAX_BLOCKS);

  cfg_t                     cfg_regs;
  ring_cmd_t                ring_cmd;
  logic [IDX_W-1:0]         ring_idx;
  logic [ADDRESS_WIDTH-1:0] ring_wdata;
  logic [ADDRESS_WIDTH-1:0] ring_rdata;

  // Writes are always taken; an index beyond the register list is ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.base_address <= '0;
      cfg_regs.block_size   <= SIZE_W'(64);
      cfg_regs.block_count  <= COUNT_W'(256);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BASE_ADDRESS: cfg_regs.base_address <= IN_ADDR_W'(cfg.data);
        REG_BLOCK_SIZE:   cfg_regs.block_size   <= cfg.data[SIZE_W-1:0];
        REG_BLOCK_COUNT:  cfg_regs.block_count  <= cfg.data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fbpa_ctrl #(
    .MAX_BLOCKS    (MAX_BLOCKS),
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_regs   (cfg_regs),
    .req        (req),
    .rsp        (rsp),
    .ring_cmd   (ring_cmd),
    .ring_idx   (ring_idx),
    .ring_wdata (ring_wdata),
    .ring_rdata (ring_rdata)
  );

  fbpa_ring_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (ADDRESS_WIDTH)
  ) u_ring (
    .clk   (clk),
    .cmd   (ring_cmd),
    .idx   (ring_idx),
    .wdata (ring_wdata),
    .rdata (ring_rdata)
  );

endmodule

/* tb/sv/fbpa_checker.sv */
// Scoreboard for the fixed block pool allocator: watches the configuration,
// request and result channels, predicts every result item and compares.
// Depends on fbpa_pkg and the channel interfaces in fbpa_if.
module fbpa_checker (
  input  logic clk,
  input  logic rst,
  fbpa_cfg_if  cfg,
  fbpa_req_if  req,
  fbpa_rsp_if  rsp,
  output int   mismatches,
  output int   pending
);
  import fbpa_pkg::*;

  localparam int RING_IDX_W = $clog2(MAX_BLOCKS_DEF);

  // Shadow copy of the registers and of the free list.
  logic [IN_ADDR_W-1:0]  pool_base;
  logic [SIZE_W-1:0]     pool_stride;
  logic [COUNT_W-1:0]    pool_count;
  logic [OUT_ADDR_W-1:0] addr_ring [MAX_BLOCKS_DEF];
  logic [RING_IDX_W-1:0] head_ptr;
  logic [RING_IDX_W-1:0] tail_ptr;
  logic [OUT_CNT_W-1:0]  free_total;

  res_t outcome_q[$];
  int   fails = 0;

  // Applies one request to the shadow free list and returns its result item.
  function automatic res_t apply_request(input logic [OP_W-1:0] op,
                                         input logic [IN_ADDR_W-1:0] addr);
    res_t                  r;
    logic [OUT_ADDR_W-1:0] a;
    int                    n;
    r.status          = ST_OK;
    r.granted_address = '0;
    case (op)
      OP_ALLOC: begin
        if (free_total == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.granted_address = addr_ring[head_ptr];
          head_ptr          = head_ptr + RING_IDX_W'(1);
          free_total        = free_total - OUT_CNT_W'(1);
        end
      end
      OP_FREE: begin
        if (32'(free_total) >= MAX_BLOCKS_DEF) begin
          r.status = ST_FULL;
        end else begin
          addr_ring[tail_ptr] = addr;
          tail_ptr            = tail_ptr + RING_IDX_W'(1);
          free_total          = free_total + OUT_CNT_W'(1);
        end
      end
      OP_INIT: begin
        // The block count saturates at the ring depth; the stride wraps
        // the address silently.
        n = (32'(pool_count) > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(pool_count);
        a = pool_base;
        for (int i = 0; i < n; i++) begin
          addr_ring[i] = a;
          a            = a + OUT_ADDR_W'(pool_stride);
        end
        head_ptr   = '0;
        tail_ptr   = n[RING_IDX_W-1:0];
        free_total = n[OUT_CNT_W-1:0];
      end
      default: begin
      end
    endcase
    r.free_blocks = free_total;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      pool_base   = '0;
      pool_stride = SIZE_W'(64);
      pool_count  = COUNT_W'(256);
      head_ptr    = '0;
      tail_ptr    = '0;
      free_total  = '0;
      outcome_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_BASE_ADDRESS: pool_base = cfg.data[IN_ADDR_W-1:0];
          REG_BLOCK_SIZE:   pool_stride = cfg.data[SIZE_W-1:0];
          REG_BLOCK_COUNT:  pool_count = cfg.data[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
      // A result always belongs to an earlier request, so it is matched
      // before this edge's request is added.
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          if (fails < 10)
            $display("unexpected result item: status %0d addr %h free %0d",
                     rsp.status, rsp.granted_address, rsp.free_blocks);
          fails++;
        end else begin
          want = outcome_q.pop_front();
          if (rsp.status !== want.status || rsp.granted_address !== want.granted_address ||
              rsp.free_blocks !== want.free_blocks) begin
            if (fails < 10)
              $display("result mismatch (status/addr/free): expected %0d/%h/%0d, got %0d/%h/%0d",
                       want.status, want.granted_address, want.free_blocks,
                       rsp.status, rsp.granted_address, rsp.free_blocks);
            fails++;
          end
        end
      end
      if (req.valid && req.ready)
        outcome_q.push_back(apply_request(req.operation, req.block_address));
    end
    mismatches <= fails;
    pending    <= outcome_q.size();
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the fixed block pool allocator testbench: clock, reset, stimulus,
// receiver back-pressure, a watchdog and the final verdict.
// Depends on fbpa_pkg, fbpa_if, the block itself and fbpa_checker.
module testbench;
  import fbpa_pkg::*;

  // Codes that the package leaves unnamed: the spare operation and the spare
  // register index, both of which the block must treat as no-ops.
  localparam logic [OP_W-1:0]      OP_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int HOLD_CYCLES  = 300;   // length of the long receiver hold-off
  localparam int IDLE_LIMIT   = 5000;  // cycles without any item before giving up
  localparam int PHASE_ITEMS  = 420;   // random items per idling phase

  logic clk = 1'b0;
  logic rst = 1'b1;

  fbpa_cfg_if cfg_ch ();
  fbpa_req_if req_ch ();
  fbpa_rsp_if rsp_ch ();

  int mismatches;
  int pending;
  int items_sent    = 0;
  int gap_pct       = 0;   // chance in a hundred that the sender idles a cycle
  int stall_pct     = 0;   // chance in a hundred that the receiver stalls a cycle
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  fixed_block_pool_allocator uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  fbpa_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Reset is held at the start and never raised again.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Receiver side. A hold-off request from the stimulus turns into a long run
  // of stalled cycles counted here; otherwise ready follows the current
  // stall percentage.
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served   <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      rsp_ch.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      rsp_ch.ready  <= 1'b0;
    end else begin
      rsp_ch.ready  <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: any accepted item on any channel counts as progress.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item accepted for %0d cycles", IDLE_LIMIT);
      $display("[fixed_block_pool_allocator] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Writes one register. The valid is dropped for a cycle afterwards, so
  // back-to-back writes never lower and raise it in the same time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one request item and returns at the edge where it is accepted.
  // The valid stays high on return, so the next item can follow straight
  // away; a gap, when drawn, lowers it first.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IN_ADDR_W-1:0] addr);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= op;
    req_ch.block_address <= addr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stops offering and waits until every expected result item has arrived,
  // then lets the block settle. Registers are only written after this.
  task automatic drain(input int settle);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // One well-formed stretch of traffic: a fresh configuration, an initialise
  // and then a random mix of allocates and frees, with the odd re-initialise
  // and spare operation code thrown in.
  task automatic run_segment(input int n_items, input bit with_hold);
    logic [IN_ADDR_W-1:0] base_v;
    logic [SIZE_W-1:0]    size_v;
    logic [COUNT_W-1:0]   count_v;
    logic [IN_ADDR_W-1:0] addr;
    int                   free_pct;
    int                   roll;
    drain(2);

    case ($urandom_range(7))
      0:       base_v = '0;
      1:       base_v = '1;
      2:       base_v = 32'hFFFF_0000 | $urandom_range(65535);
      default: base_v = $urandom();
    endcase
    case ($urandom_range(9))
      0:       size_v = SIZE_W'($urandom_range(7));
      1:       size_v = SIZE_W'(65536);
      2:       size_v = SIZE_W'($urandom_range(131071, 65537));
      3:       size_v = SIZE_W'(8);
      default: size_v = SIZE_W'($urandom_range(65536, 8));
    endcase
    case ($urandom_range(9))
      0:       count_v = '0;
      1:       count_v = COUNT_W'(256);
      2:       count_v = COUNT_W'($urandom_range(511, 257));
      3:       count_v = COUNT_W'(1);
      4, 5, 6: count_v = COUNT_W'($urandom_range(64, 2));
      default: count_v = COUNT_W'($urandom_range(255, 65));
    endcase
    // Upper data bits are random so that the register masking is exercised.
    write_reg(REG_BASE_ADDRESS, base_v);
    write_reg(REG_BLOCK_SIZE, ({$urandom()} & ~32'h1FFFF) | CFG_DATA_W'(size_v));
    write_reg(REG_BLOCK_COUNT, ({$urandom()} & ~32'h1FF) | CFG_DATA_W'(count_v));

    send_item(OP_INIT, $urandom());
    // The long hold-off starts while the initialise is in work; the sender
    // keeps offering so the holding register fills and the input stalls.
    if (with_hold) hold_requests <= hold_requests + 1;

    // Bias the segment towards draining, churning or filling the list.
    case ($urandom_range(2))
      0:       free_pct = 20;
      1:       free_pct = 45;
      default: free_pct = 72;
    endcase
    for (int k = 1; k < n_items; k++) begin
      roll = $urandom_range(99);
      // Returned addresses mostly look like pool blocks, sometimes anything.
      if ($urandom_range(3) == 0) addr = $urandom();
      else addr = base_v + $urandom_range(255) * IN_ADDR_W'(size_v);
      if (roll < 3)                 send_item(OP_INIT, addr);
      else if (roll < 6)            send_item(OP_SPARE, addr);
      else if (roll < 6 + free_pct) send_item(OP_FREE, addr);
      else                          send_item(OP_ALLOC, addr);
    end
  endtask

  initial begin
    int target;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= REG_BASE_ADDRESS;
    cfg_ch.data          <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.operation     <= OP_ALLOC;
    req_ch.block_address <= '0;
    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed part. Straight after reset the list is empty: an allocate
    // must report empty, and the spare operation code must change nothing.
    send_item(OP_ALLOC, '0);
    send_item(OP_SPARE, '1);
    send_item(OP_FREE, '1);
    send_item(OP_FREE, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '1);

    // Addresses near the top of the space with the largest legal stride
    // wrap round past the top of the space.
    drain(2);
    write_reg(REG_BASE_ADDRESS, 32'hFFFF_FFC0);
    write_reg(REG_BLOCK_SIZE, 32'd65536);
    write_reg(REG_BLOCK_COUNT, 32'd3);
    send_item(OP_INIT, '0);
    repeat (3) send_item(OP_ALLOC, '0);

    // A zero stride hands out the same address every time, and a block
    // count above the ring depth saturates, so a following free is dropped
    // as the list is full.
    drain(2);
    write_reg(REG_BLOCK_SIZE, 32'd0);
    write_reg(REG_BLOCK_COUNT, 32'd511);
    write_reg(REG_BASE_ADDRESS, 32'h1234_5678);
    send_item(OP_INIT, '0);
    send_item(OP_FREE, 32'hA5A5_A5A5);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 32'h5A5A_5A5A);

    // A count of zero empties the list; the stride is at its register
    // maximum, well above the legal range. The spare register index must
    // be ignored.
    drain(2);
    write_reg(REG_BLOCK_SIZE, 32'h0001_FFFF);
    write_reg(REG_BLOCK_COUNT, 32'd0);
    write_reg(REG_SPARE, '1);
    send_item(OP_INIT, '1);
    send_item(OP_ALLOC, '0);

    // Smallest legal stride from address zero.
    drain(2);
    write_reg(REG_BASE_ADDRESS, 32'd0);
    write_reg(REG_BLOCK_SIZE, 32'd8);
    write_reg(REG_BLOCK_COUNT, 32'd2);
    send_item(OP_INIT, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);

    // Random part in four idling phases: none, sender gaps, receiver
    // stalls, then both at once. The first phase carries the long hold-off.
    for (int phase = 0; phase < 4; phase++) begin
      drain(2);
      case (phase)
        0:       begin gap_pct = 0;  stall_pct <= 0;  end
        1:       begin gap_pct = 48; stall_pct <= 0;  end
        2:       begin gap_pct = 0;  stall_pct <= 48; end
        default: begin gap_pct = 15; stall_pct <= 15; end
      endcase
      target = items_sent + PHASE_ITEMS;
      run_segment($urandom_range(140, 60), phase == 0);
      while (items_sent < target)
        run_segment($urandom_range(140, 60), 1'b0);
    end

    // Allow for the longest initialise walk before the verdict.
    drain(MAX_BLOCKS_DEF + 40);
    if (mismatches == 0 && pending == 0) begin
      $display("[fixed_block_pool_allocator] OK");
    end else begin
      $display("[fixed_block_pool_allocator] ERROR");
    end
    $finish;
  end

endmodule
